FILE: hw/rtl/nnps_pkg.sv
// ----------------------------------------------------------------------------
// nnps_pkg
// Shared constants, register codes and control types of the plane scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnps_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int MAX_RATIO  = 8;
   localparam int DIM_W      = 13;
   localparam int CNT_W      = 12;
   localparam int ACC_W      = 25;
   localparam int RATIO_W    = 4;
   localparam int VALUE_W    = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_SEL_W  = 2;

   typedef enum logic [CSR_SEL_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_TARGET_WIDTH  = 2'd2,
      CSR_TARGET_HEIGHT = 2'd3
   } csr_sel_type;

   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] dst_w;
      logic [DIM_W-1:0] dst_h;
   } sizes_type;

   typedef struct packed {
      logic start;
      logic load_row_limit;
      logic row_step;
      logic load_col_limit;
      logic col_step;
      logic emit;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic start_col_zero;
      logic row_more;
      logic col_more;
      logic out_free;
      logic emit_empty;
      logic emit_last;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nnps_channels.sv
// ----------------------------------------------------------------------------
// nnps_channels
// Valid/ready channels for source samples and produced samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnps_req_if;
   import nnps_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface nnps_rsp_if;
   import nnps_pkg::*;
   logic               valid;
   logic               ready;
   logic [CNT_W-1:0]   out_column;
   logic [CNT_W-1:0]   out_row;
   logic [VALUE_W-1:0] out_value;
   logic               run_last;
   logic               clipped;

   modport source (output valid, output out_column, output out_row, output out_value,
                   output run_last, output clipped, input ready);
   modport sink   (input valid, input out_column, input out_row, input out_value,
                   input run_last, input clipped, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nnps_csr.sv
// ----------------------------------------------------------------------------
// nnps_csr
// APB-style size registers with clamped effective sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module nnps_csr
   import nnps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output sizes_type                  sizes
);

   logic [DIM_W-1:0] src_w_ff, src_w_in;
   logic [DIM_W-1:0] src_h_ff, src_h_in;
   logic [DIM_W-1:0] dst_w_ff, dst_w_in;
   logic [DIM_W-1:0] dst_h_ff, dst_h_in;
   logic             wr_en;
   csr_sel_type      sel;
   logic [DIM_W-1:0] rd_val;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign sel   = csr_sel_type'(csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_SEL_W]);

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      rd_val   = src_w_ff;
      unique case (sel)
         CSR_SOURCE_WIDTH: begin
            rd_val = src_w_ff;
            if (wr_en) src_w_in = csr_pwdata[DIM_W-1:0];
         end
         CSR_SOURCE_HEIGHT: begin
            rd_val = src_h_ff;
            if (wr_en) src_h_in = csr_pwdata[DIM_W-1:0];
         end
         CSR_TARGET_WIDTH: begin
            rd_val = dst_w_ff;
            if (wr_en) dst_w_in = csr_pwdata[DIM_W-1:0];
         end
         CSR_TARGET_HEIGHT: begin
            rd_val = dst_h_ff;
            if (wr_en) dst_h_in = csr_pwdata[DIM_W-1:0];
         end
         default: begin
            rd_val = src_w_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_W'(1);
         src_h_ff <= DIM_W'(1);
         dst_w_ff <= DIM_W'(1);
         dst_h_ff <= DIM_W'(1);
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
      end
   end

   assign csr_prdata  = CSR_DATA_W'(rd_val);
   assign csr_pready  = 1'b1;
   assign sizes.src_w = eff_size(src_w_ff);
   assign sizes.src_h = eff_size(src_h_ff);
   assign sizes.dst_w = eff_size(dst_w_ff);
   assign sizes.dst_h = eff_size(dst_h_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/nnps_ctrl.sv
// ----------------------------------------------------------------------------
// nnps_ctrl
// Sequencer: accept, row search, column search, word emission, advance.
// ----------------------------------------------------------------------------
`default_nettype none

module nnps_ctrl
   import nnps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_LIMIT,
      ST_ROW_STEP,
      ST_COL_LIMIT,
      ST_COL_STEP,
      ST_EMIT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.start_col_zero ? ST_ROW_LIMIT : ST_COL_LIMIT;
            end
         end
         ST_ROW_LIMIT: begin
            cmd.load_row_limit = 1'b1;
            state_in           = ST_ROW_STEP;
         end
         ST_ROW_STEP: begin
            if (status.row_more) begin
               cmd.row_step = 1'b1;
            end else begin
               state_in = ST_COL_LIMIT;
            end
         end
         ST_COL_LIMIT: begin
            cmd.load_col_limit = 1'b1;
            state_in           = ST_COL_STEP;
         end
         ST_COL_STEP: begin
            if (status.col_more) begin
               cmd.col_step = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.emit_empty) begin
               state_in = ST_FINISH;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/nnps_datapath.sv
// ----------------------------------------------------------------------------
// nnps_datapath
// Source counters, destination accumulators, limit multiplier, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module nnps_datapath
   import nnps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  sizes_type                sizes,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  wire logic [VALUE_W-1:0]  req_sample,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic      [CNT_W-1:0]    rsp_column,
   output logic      [CNT_W-1:0]    rsp_row,
   output logic      [VALUE_W-1:0]  rsp_value,
   output logic                     rsp_last,
   output logic                     rsp_clipped
);

   // persistent scan state
   logic [CNT_W-1:0]   src_col_ff, src_col_in;
   logic [CNT_W-1:0]   src_row_ff, src_row_in;
   logic [DIM_W-1:0]   next_col_ff, next_col_in;
   logic [ACC_W-1:0]   col_acc_ff, col_acc_in;
   logic [DIM_W-1:0]   row_first_ff, row_first_in;
   logic [RATIO_W-1:0] row_cnt_ff, row_cnt_in;
   logic [DIM_W-1:0]   next_row_ff, next_row_in;
   logic [ACC_W-1:0]   row_acc_ff, row_acc_in;
   // per-sample working state
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [DIM_W-1:0]   first_col_ff, first_col_in;
   logic [RATIO_W-1:0] col_cnt_ff, col_cnt_in;
   logic               col_clip_ff, col_clip_in;
   logic [ACC_W-1:0]   limit_ff, limit_in;
   logic [RATIO_W-1:0] i_ff, i_in;
   logic [RATIO_W-1:0] j_ff, j_in;
   // output word
   logic               out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]   out_col_ff, out_col_in;
   logic [CNT_W-1:0]   out_row_ff, out_row_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in;
   logic               out_clip_ff, out_clip_in;

   logic [CNT_W-1:0]     col_wrap, row_wrap;
   logic [DIM_W-1:0]     mul_a, mul_b;
   logic [2*DIM_W-1:0]   product;
   logic [DIM_W:0]       row_end;
   logic                 clip;
   logic [DIM_W-1:0]     col_next, row_next;

   assign col_wrap = (DIM_W'(src_col_ff) >= sizes.src_w) ? '0 : src_col_ff;
   assign row_wrap = (DIM_W'(src_row_ff) >= sizes.src_h) ? '0 : src_row_ff;

   assign mul_a   = cmd.load_row_limit ? DIM_W'(src_row_ff) + 1'b1
                                       : DIM_W'(src_col_ff) + 1'b1;
   assign mul_b   = cmd.load_row_limit ? sizes.dst_h : sizes.dst_w;
   assign product = mul_a * mul_b;

   assign row_end = (DIM_W+1)'(row_first_ff) + (DIM_W+1)'(row_cnt_ff);
   assign clip    = col_clip_ff || ((DIM_W+1)'(next_row_ff) > row_end);

   assign col_next = DIM_W'(src_col_ff) + 1'b1;
   assign row_next = DIM_W'(src_row_ff) + 1'b1;

   assign status.start_col_zero = (col_wrap == '0);
   assign status.row_more       = (next_row_ff < sizes.dst_h) && (row_acc_ff < limit_ff);
   assign status.col_more       = (next_col_ff < sizes.dst_w) && (col_acc_ff < limit_ff);
   assign status.out_free       = !out_valid_ff || rsp_ready;
   assign status.emit_empty     = (row_cnt_ff == '0) || (col_cnt_ff == '0);
   assign status.emit_last      = (i_ff + 1'b1 == row_cnt_ff) && (j_ff + 1'b1 == col_cnt_ff);

   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      next_col_in  = next_col_ff;
      col_acc_in   = col_acc_ff;
      row_first_in = row_first_ff;
      row_cnt_in   = row_cnt_ff;
      next_row_in  = next_row_ff;
      row_acc_in   = row_acc_ff;
      value_in     = value_ff;
      first_col_in = first_col_ff;
      col_cnt_in   = col_cnt_ff;
      col_clip_in  = col_clip_ff;
      limit_in     = limit_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_clip_in  = out_clip_ff;
      out_valid_in = rsp_ready ? 1'b0 : out_valid_ff;

      if (cmd.start) begin
         value_in     = req_sample;
         src_col_in   = col_wrap;
         src_row_in   = row_wrap;
         col_cnt_in   = '0;
         col_clip_in  = 1'b0;
         i_in         = '0;
         j_in         = '0;
         first_col_in = next_col_ff;
         if (col_wrap == '0) begin
            next_col_in  = '0;
            col_acc_in   = '0;
            first_col_in = '0;
            row_cnt_in   = '0;
            row_first_in = next_row_ff;
            if (row_wrap == '0) begin
               next_row_in  = '0;
               row_acc_in   = '0;
               row_first_in = '0;
            end
         end
      end

      if (cmd.load_row_limit || cmd.load_col_limit) begin
         limit_in = product[ACC_W-1:0];
      end

      if (cmd.row_step) begin
         next_row_in = next_row_ff + 1'b1;
         row_acc_in  = row_acc_ff + ACC_W'(sizes.src_h);
         if (row_cnt_ff != RATIO_W'(MAX_RATIO)) row_cnt_in = row_cnt_ff + 1'b1;
      end

      if (cmd.col_step) begin
         next_col_in = next_col_ff + 1'b1;
         col_acc_in  = col_acc_ff + ACC_W'(sizes.src_w);
         if (col_cnt_ff != RATIO_W'(MAX_RATIO)) begin
            col_cnt_in = col_cnt_ff + 1'b1;
         end else begin
            col_clip_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_col_in   = first_col_ff[CNT_W-1:0] + CNT_W'(j_ff);
         out_row_in   = row_first_ff[CNT_W-1:0] + CNT_W'(i_ff);
         out_value_in = value_ff;
         out_last_in  = status.emit_last;
         out_clip_in  = clip;
         if (j_ff + 1'b1 == col_cnt_ff) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end

      if (cmd.finish) begin
         if (col_next >= sizes.src_w) begin
            src_col_in = '0;
            src_row_in = (row_next >= sizes.src_h) ? '0 : row_next[CNT_W-1:0];
         end else begin
            src_col_in = col_next[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         next_col_ff  <= '0;
         col_acc_ff   <= '0;
         row_first_ff <= '0;
         row_cnt_ff   <= '0;
         next_row_ff  <= '0;
         row_acc_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         next_col_ff  <= next_col_in;
         col_acc_ff   <= col_acc_in;
         row_first_ff <= row_first_in;
         row_cnt_ff   <= row_cnt_in;
         next_row_ff  <= next_row_in;
         row_acc_ff   <= row_acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      first_col_ff <= first_col_in;
      col_cnt_ff   <= col_cnt_in;
      col_clip_ff  <= col_clip_in;
      limit_ff     <= limit_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_clip_ff  <= out_clip_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_column  = out_col_ff;
   assign rsp_row     = out_row_ff;
   assign rsp_value   = out_value_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_clipped = out_clip_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/nearest_neighbor_plane_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_plane_scaler
// Streaming nearest-neighbor scaler for one 8-bit plane in raster order.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid/ready     sample_value
//   rsp_chan  out   valid/ready     out_column, out_row, out_value, run_last,
//                                   clipped
//   csr_*     in    apb write/read  source/target width and height
//
// one sample at a time; per sample a limit load and a search through the
// destination rows (at source column 0 only), then a limit load and a search
// through the destination columns, stepped one per cycle by the accumulators,
// and then the results; results leave through an output register; rsp stalls hold the emitter
// the next sample is taken while the last result still waits in that register
// synchronous reset clears counters, accumulators and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_plane_scaler
   import nnps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   nnps_req_if.sink                   req_chan,
   nnps_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   sizes_type     sizes;
   dp_cmd_type    cmd;
   dp_status_type status;

   nnps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .sizes       (sizes)
   );

   nnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nnps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .sizes       (sizes),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_chan.sample_value),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_column  (rsp_chan.out_column),
      .rsp_row     (rsp_chan.out_row),
      .rsp_value   (rsp_chan.out_value),
      .rsp_last    (rsp_chan.run_last),
      .rsp_clipped (rsp_chan.clipped)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/nnps_checker.sv
// ----------------------------------------------------------------------------
// nnps_checker
// Port-level checks of the plane scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nnps_checker
   import nnps_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [CNT_W-1:0]   rsp_column,
   input wire logic [CNT_W-1:0]   rsp_row,
   input wire logic [VALUE_W-1:0] rsp_value,
   input wire logic               rsp_run_last,
   input wire logic               rsp_clipped
);

   // a word stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped before taken");

   // a stalled word holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_column) && $stable(rsp_row)
         && $stable(rsp_value) && $stable(rsp_run_last) && $stable(rsp_clipped))
      else $error("rsp payload changed while stalled");

   // one sample at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken again right after a sample");

   // no new sample while a run is still being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !req_ready)
      else $error("req ready in the middle of a run");

endmodule

bind nearest_neighbor_plane_scaler nnps_checker u_nnps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_column   (rsp_chan.out_column),
   .rsp_row      (rsp_chan.out_row),
   .rsp_value    (rsp_chan.out_value),
   .rsp_run_last (rsp_chan.run_last),
   .rsp_clipped  (rsp_chan.clipped)
);

`default_nettype wire

FILE: tb/nearest_neighbor_plane_scaler_test.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_plane_scaler_test
// Self-checking bench for the streaming nearest-neighbor plane scaler. A
// directed table covers reset sizes, zero and oversize registers, column and
// row ratio caps, halving, doubling, copy and counters left beyond a shrunk
// size. Random phases follow, most with fresh random sizes. Each produced word
// is checked against the table's expected word or a cycle-free model of the
// scaler, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------

module nearest_neighbor_plane_scaler_test;
   import nnps_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]   column;
      logic [CNT_W-1:0]   row;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               clip;
   } pixel_type;

   typedef struct packed {
      logic               is_cfg;
      csr_sel_type        sel;
      logic [31:0]        data;
      logic [VALUE_W-1:0] sample;
      logic               typed;
      pixel_type          want;
   } plan_step_type;

   localparam pixel_type NO_PIXEL     = '0;
   localparam int        PLAN_LEN     = 46;
   localparam int        QUIET_LIMIT  = 200000;
   localparam int        LONG_HOLD    = 300;
   localparam int        RANDOM_ITEMS = 180;

   plan_step_type directed_plan [PLAN_LEN] = '{
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h00, 1'b1, '{12'd0, 12'd0, 8'h00, 1'b1, 1'b0}},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'hFF, 1'b1, '{12'd0, 12'd0, 8'hFF, 1'b1, 1'b0}},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h5A, 1'b1, '{12'd0, 12'd0, 8'h5A, 1'b1, 1'b0}},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'hA5, 1'b1, '{12'd0, 12'd0, 8'hA5, 1'b1, 1'b0}},
      // zero sizes act as one
      '{1'b1, CSR_SOURCE_WIDTH,  32'd0,         8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_WIDTH,  32'hFFFF_E000, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h3C, 1'b1, '{12'd0, 12'd0, 8'h3C, 1'b1, 1'b0}},
      // column doubling, ten rows per source row hits the row cap
      '{1'b1, CSR_SOURCE_WIDTH,  32'd3,  8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_WIDTH,  32'd6,  8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_SOURCE_HEIGHT, 32'd2,  8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_HEIGHT, 32'd20, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h11, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h22, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h33, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h44, 1'b0, NO_PIXEL},
      // column cap
      '{1'b1, CSR_SOURCE_WIDTH,  32'd1,  8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_WIDTH,  32'd20, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_SOURCE_HEIGHT, 32'd1,  8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_HEIGHT, 32'd1,  8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h81, 1'b0, NO_PIXEL},
      // halving, odd columns and odd rows give nothing
      '{1'b1, CSR_SOURCE_WIDTH,  32'd8, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_WIDTH,  32'd4, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_SOURCE_HEIGHT, 32'd2, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_HEIGHT, 32'd1, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h01, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h02, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h04, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h08, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h10, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h20, 1'b0, NO_PIXEL},
      // copy, column counter is beyond the new width
      '{1'b1, CSR_SOURCE_WIDTH,  32'd5, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_WIDTH,  32'd5, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_SOURCE_HEIGHT, 32'd5, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_HEIGHT, 32'd5, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h40, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h80, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'hC3, 1'b0, NO_PIXEL},
      '{1'b1, CSR_SOURCE_WIDTH,  32'd2, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h7E, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'hE7, 1'b0, NO_PIXEL},
      // full and oversize registers
      '{1'b1, CSR_SOURCE_WIDTH,  32'h0000_1FFF, 8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_WIDTH,  32'd4096,      8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_SOURCE_HEIGHT, 32'd4096,      8'h00, 1'b0, NO_PIXEL},
      '{1'b1, CSR_TARGET_HEIGHT, 32'h0000_1FFF, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'h00, 1'b0, NO_PIXEL},
      '{1'b0, CSR_SOURCE_WIDTH,  32'd0, 8'hFF, 1'b0, NO_PIXEL}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   nnps_req_if req_chan ();
   nnps_rsp_if rsp_chan ();

   nearest_neighbor_plane_scaler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scaler model state
   logic [DIM_W-1:0]   size_reg [4];
   logic [CNT_W-1:0]   col_pos;
   logic [CNT_W-1:0]   row_pos;
   logic [DIM_W-1:0]   dest_col;
   logic [ACC_W-1:0]   col_acc;
   logic [DIM_W-1:0]   row_first;
   logic [RATIO_W-1:0] row_count;
   logic [DIM_W-1:0]   dest_row;
   logic [ACC_W-1:0]   row_acc;

   pixel_type pending_pixels [$];
   int        failures;
   int        quiet_cycles;
   bit        block_busy;
   bit        send_burst;
   bit        rsp_burst;
   bit        long_hold_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int clamp_dimension(input logic [DIM_W-1:0] v);
      int r;
      r = int'(v);
      if (r == 0) r = 1;
      else if (r > MAX_DIM) r = MAX_DIM;
      return r;
   endfunction

   task automatic clear_scaler_state();
      for (int i = 0; i < 4; i++) size_reg[i] = DIM_W'(1);
      col_pos   = '0;
      row_pos   = '0;
      dest_col  = '0;
      col_acc   = '0;
      row_first = '0;
      row_count = '0;
      dest_row  = '0;
      row_acc   = '0;
   endtask

   task automatic scale_sample(input logic [VALUE_W-1:0] v, input bit keep);
      int               sw, sh, dw, dh;
      int               raw_rows, raw_cols, ncols;
      longint unsigned  bound;
      logic [DIM_W-1:0] first_col;
      bit               clip;
      pixel_type        word;
      sw = clamp_dimension(size_reg[CSR_SOURCE_WIDTH]);
      sh = clamp_dimension(size_reg[CSR_SOURCE_HEIGHT]);
      dw = clamp_dimension(size_reg[CSR_TARGET_WIDTH]);
      dh = clamp_dimension(size_reg[CSR_TARGET_HEIGHT]);
      if (int'(col_pos) >= sw) col_pos = '0;
      if (int'(row_pos) >= sh) row_pos = '0;
      if (col_pos == 0) begin
         raw_rows = 0;
         if (row_pos == 0) begin
            dest_row = '0;
            row_acc  = '0;
         end
         dest_col  = '0;
         col_acc   = '0;
         row_first = dest_row;
         bound     = (longint'(row_pos) + 1) * dh;
         while (int'(dest_row) < dh && longint'(row_acc) < bound) begin
            dest_row = dest_row + 1'b1;
            row_acc  = row_acc + ACC_W'(sh);
            raw_rows++;
         end
         row_count = RATIO_W'((raw_rows > MAX_RATIO) ? MAX_RATIO : raw_rows);
      end
      first_col = dest_col;
      raw_cols  = 0;
      bound     = (longint'(col_pos) + 1) * dw;
      while (int'(dest_col) < dw && longint'(col_acc) < bound) begin
         dest_col = dest_col + 1'b1;
         col_acc  = col_acc + ACC_W'(sw);
         raw_cols++;
      end
      ncols = (raw_cols > MAX_RATIO) ? MAX_RATIO : raw_cols;
      clip  = (raw_cols > ncols) || (int'(dest_row) > int'(row_first) + int'(row_count));
      if (keep) begin
         for (int i = 0; i < int'(row_count); i++) begin
            for (int j = 0; j < ncols; j++) begin
               word.column = CNT_W'(int'(first_col) + j);
               word.row    = CNT_W'(int'(row_first) + i);
               word.value  = v;
               word.last   = (i + 1 == int'(row_count)) && (j + 1 == ncols);
               word.clip   = clip;
               pending_pixels.push_back(word);
            end
         end
      end
      if (int'(col_pos) + 1 >= sw) begin
         col_pos = '0;
         if (int'(row_pos) + 1 >= sh) row_pos = '0;
         else row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   task automatic write_register(input csr_sel_type sel, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      size_reg[sel] = data[DIM_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_sample(input logic [VALUE_W-1:0] v, input bit typed,
                              input pixel_type want);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sample_value <= v;
      do @(posedge clock); while (!req_chan.ready);
      scale_sample(v, !typed);
      if (typed) pending_pixels.push_back(want);
      block_busy = 1'b1;
      @(negedge clock);
   endtask

   // drain all words, then give a word-less sample time to finish
   task automatic settle_block();
      int drain;
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      drain = 3 * (clamp_dimension(size_reg[CSR_TARGET_WIDTH]) +
                   clamp_dimension(size_reg[CSR_TARGET_HEIGHT])) + 300;
      repeat (drain) @(negedge clock);
      block_busy = 1'b0;
   endtask

   function automatic logic [31:0] random_size_word();
      logic [DIM_W-1:0] size;
      logic [31:0]      word;
      case ($urandom_range(0, 19))
         0:       size = '0;
         1:       size = DIM_W'($urandom_range(4096, 8191));
         2, 3, 4: size = DIM_W'($urandom_range(13, 64));
         default: size = DIM_W'($urandom_range(1, 12));
      endcase
      word = {19'd0, size};
      if ($urandom_range(0, 3) == 0) word = ($urandom() & 32'hFFFF_E000) | word;
      return word;
   endfunction

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // result word checker
   initial begin
      int        gap;
      pixel_type want;
      pixel_type got;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 12);
         if (long_hold_req) begin
            gap = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got = '{rsp_chan.out_column, rsp_chan.out_row, rsp_chan.out_value,
                 rsp_chan.run_last, rsp_chan.clipped};
         if (pending_pixels.size() == 0) begin
            failures++;
            $display("%0t: unexpected word col=%0d row=%0d value=%h last=%b clip=%b",
                     $time, got.column, got.row, got.value, got.last, got.clip);
         end else begin
            want = pending_pixels.pop_front();
            if (got.column !== want.column || got.row !== want.row ||
                got.value !== want.value || got.last !== want.last ||
                got.clip !== want.clip) begin
               failures++;
               $display("%0t: mismatch expected col=%0d row=%0d value=%h last=%b clip=%b",
                        $time, want.column, want.row, want.value, want.last, want.clip);
               $display("%0t:          actual col=%0d row=%0d value=%h last=%b clip=%b",
                        $time, got.column, got.row, got.value, got.last, got.clip);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      int            random_count;
      int            phase;
      int            count;
      int            big;
      plan_step_type step;
      failures      = 0;
      quiet_cycles  = 0;
      block_busy    = 1'b0;
      send_burst    = 1'b0;
      rsp_burst     = 1'b0;
      long_hold_req = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.sample_value = '0;
      rsp_chan.ready        = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      clear_scaler_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         step = directed_plan[i];
         if (step.is_cfg) begin
            if (block_busy) settle_block();
            write_register(step.sel, step.data);
         end else begin
            send_sample(step.sample, step.typed, step.want);
         end
      end

      random_count = 0;
      phase = 0;
      while (random_count < RANDOM_ITEMS) begin
         settle_block();
         if (phase == 1) begin
            // small upscale so that the output backs up during the long hold
            write_register(CSR_SOURCE_WIDTH, 32'd2);
            write_register(CSR_TARGET_WIDTH, 32'd6);
            write_register(CSR_SOURCE_HEIGHT, 32'd2);
            write_register(CSR_TARGET_HEIGHT, 32'd4);
         end else begin
            for (int r = 0; r < 4; r++) begin
               if (phase == 0 || $urandom_range(0, 3) != 0)
                  write_register(csr_sel_type'(r), random_size_word());
            end
         end
         big = 0;
         for (int r = 0; r < 4; r++) begin
            if (clamp_dimension(size_reg[r]) > 64) big = 1;
         end
         count = big ? $urandom_range(2, 5) : $urandom_range(12, 36);
         send_burst = ($urandom_range(0, 3) == 0);
         rsp_burst  = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            send_burst    = 1'b1;
            long_hold_req = 1'b1;
         end
         for (int k = 0; k < count; k++) begin
            send_sample(VALUE_W'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
            random_count++;
         end
         phase++;
      end

      settle_block();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
